FILE: hw/rtl/heading_pursuit_controller_macros.svh
// Assertion macros for the heading pursuit controller.
// No dependencies; included by the top level only.
`ifndef HEADING_PURSUIT_CONTROLLER_MACROS_SVH
`define HEADING_PURSUIT_CONTROLLER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hpc_pkg.sv
// Shared widths, constants, register codes and the arctangent table
// for the heading pursuit controller. No dependencies.
`timescale 1ns / 1ps

package hpc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TABLE_LEN         = 24;
   localparam int TAB_IDX_W         = 5;

   localparam int POS_W      = 32;
   localparam int DIFF_W     = 33;
   localparam int CX_W       = 36;
   localparam int Z_W        = 20;
   localparam int HEAD_W     = 16;
   localparam int BEAR_W     = 17;
   localparam int ERR_W      = 18;
   localparam int DIST_W     = 31;
   localparam int GAIN_W     = 16;
   localparam int CFG_W      = 15;
   localparam int LIN_W      = 15;
   localparam int ANG_W      = 16;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [Z_W-1:0]   HALF_PI_Q16    = 20'sd102944;
   localparam logic signed [ERR_W-1:0] PI_Q13         = 18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13     = 18'sd51472;
   localparam logic [DIST_W-1:0]       HALF_METRE_Q16 = 31'd32768;

   localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 16'd6144;
   localparam logic [CFG_W-1:0]  LIN_SPEED_RST = 15'd2048;
   localparam logic [CFG_W-1:0]  DEAD_BAND_RST = 15'd2458;
   localparam logic [CFG_W-1:0]  ANG_LIMIT_RST = 15'd12288;
   localparam logic [CFG_W-1:0]  STOP_DIST_RST = 15'd6554;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANG_GAIN  = 3'd0,
      CSR_LIN_SPEED = 3'd1,
      CSR_DEAD_BAND = 3'd2,
      CSR_ANG_LIMIT = 3'd3,
      CSR_STOP_DIST = 3'd4
   } csr_idx_type;

   // atan(2^-i) in units of 2^-16 rad, rounded; zero from stage 17 on
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0:    v = 20'sd51472;
         5'd1:    v = 20'sd30385;
         5'd2:    v = 20'sd16055;
         5'd3:    v = 20'sd8150;
         5'd4:    v = 20'sd4091;
         5'd5:    v = 20'sd2047;
         5'd6:    v = 20'sd1024;
         5'd7:    v = 20'sd512;
         5'd8:    v = 20'sd256;
         5'd9:    v = 20'sd128;
         5'd10:   v = 20'sd64;
         5'd11:   v = 20'sd32;
         5'd12:   v = 20'sd16;
         5'd13:   v = 20'sd8;
         5'd14:   v = 20'sd4;
         5'd15:   v = 20'sd2;
         5'd16:   v = 20'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/hpc_cordic.sv
// Iterative CORDIC vectoring unit: one shift-add stage per cycle, returns the angle.
// Depends on hpc_pkg.
`timescale 1ns / 1ps

module hpc_cordic #(
   parameter int STAGES = hpc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [hpc_pkg::DIFF_W-1:0]   x_in,
   input  logic signed [hpc_pkg::DIFF_W-1:0]   y_in,
   output logic                                done,
   output logic signed [hpc_pkg::Z_W-1:0]      z_out
);
   import hpc_pkg::*;

   localparam int EFF   = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;
   localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1;

   logic signed [CX_W-1:0] x_ff, y_ff, x_in_w, y_in_w;
   logic signed [CX_W-1:0] x0, y0, xs, ys;
   logic signed [Z_W-1:0]  z_ff, z0, ang;
   logic [IDX_W-1:0]       idx_ff;
   logic                   busy_ff, done_ff;

   assign x_in_w = CX_W'(x_in);
   assign y_in_w = CX_W'(y_in);

   // fold left half-plane vectors into the right half-plane
   always_comb begin
      x0 = x_in_w;
      y0 = y_in_w;
      z0 = '0;
      if (x_in_w < 0) begin
         if (y_in_w >= 0) begin
            x0 = y_in_w;
            y0 = -x_in_w;
            z0 = HALF_PI_Q16;
         end else begin
            x0 = -y_in_w;
            y0 = x_in_w;
            z0 = -HALF_PI_Q16;
         end
      end
   end

   assign xs  = x_ff >>> idx_ff;
   assign ys  = y_ff >>> idx_ff;
   assign ang = atan_q16(TAB_IDX_W'(idx_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (idx_ff == IDX_W'(EFF - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x0;
         y_ff <= y0;
         z_ff <= z0;
      end else if (busy_ff) begin
         if (!y_ff[CX_W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end
      end
   end

   assign done  = done_ff;
   assign z_out = z_ff;

endmodule

FILE: hw/rtl/heading_pursuit_controller.sv
// Heading pursuit controller top level: sequencer, error wrap, gain and speed scaling.
// Depends on hpc_pkg, hpc_cordic and heading_pursuit_controller_macros.svh.
//
//   channel   direction  handshake            word
//   req_*     in         req_valid/req_stall  pose, goal, distance, flags
//   rsp_*     out        rsp_valid/rsp_stall  linear_cmd, angular_cmd, cmd_count
//   csr_*     in         csr_wr_en            register index and data
//
// A new word is accepted only after the previous one has left the final step; a normal
// word passes through the CORDIC stage on the way, and a stop word skips it.
// Reset is synchronous and restores register defaults and a zero command count.
// rsp_stall holds the finished word in the output register; the sequencer waits in
// its final step until that register frees, and req_stall stays high meanwhile.
`timescale 1ns / 1ps
`include "heading_pursuit_controller_macros.svh"

module heading_pursuit_controller #(
   parameter int CORDIC_STAGES = hpc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [hpc_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [hpc_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [hpc_pkg::HEAD_W-1:0]     req_robot_heading,
   input  logic signed [hpc_pkg::POS_W-1:0]      req_target_x,
   input  logic signed [hpc_pkg::POS_W-1:0]      req_target_y,
   input  logic [hpc_pkg::DIST_W-1:0]            req_target_dist,
   input  logic                                  req_goal_reached,
   input  logic                                  req_hit_obstacle,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hpc_pkg::LIN_W-1:0]             rsp_linear_cmd,
   output logic signed [hpc_pkg::ANG_W-1:0]      rsp_angular_cmd,
   output logic [hpc_pkg::CNT_W-1:0]             rsp_cmd_count,
   // configuration port
   input  logic                                  csr_wr_en,
   input  logic [hpc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hpc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import hpc_pkg::*;

   localparam int PROD_W  = GAIN_W + 1 + ERR_W;   // signed gain times error
   localparam int ANGR_W  = PROD_W - 12;          // after the Q12 rescale
   localparam int LPROD_W = 2 * LIN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_ROT,
      ST_ERR,
      ST_MUL,
      ST_FIN
   } state_type;

   // configuration registers
   logic [GAIN_W-1:0] ang_gain_ff;
   logic [CFG_W-1:0]  lin_speed_ff, dead_band_ff, ang_limit_ff, stop_dist_ff;

   // control
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  seq_ff, seq_in;
   logic [LIN_W-1:0]  rsp_lin_ff, rsp_lin_in;
   logic signed [ANG_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // datapath
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [HEAD_W-1:0] hd_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic                     stop_ff, zero_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [PROD_W-1:0] prod_ang_ff;
   logic [LPROD_W-1:0]       prod_lin_ff;
   logic [LIN_W-1:0]         lin_sel_ff;
   logic                     near_ff;

   logic                     accept, load_out, cordic_start, cordic_done;
   logic signed [Z_W-1:0]    cordic_z, z_round;
   logic signed [BEAR_W-1:0] bear;
   logic signed [ERR_W-1:0]  err_raw, err_wrap, err_mag;
   logic [LIN_W-1:0]         lin_sel;
   logic signed [PROD_W-1:0] prod_round;
   logic signed [ANGR_W-1:0] ang_r, ang_lim;
   logic signed [ANG_W-1:0]  ang_clamped;
   logic [LIN_W-1:0]         lin_final;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   // launch the CORDIC only for words that need a bearing
   assign cordic_start = (state_ff == ST_PRE) && !stop_ff;
   // output register free, or its word leaves this cycle
   assign load_out     = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   hpc_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .x_in   (dx_ff),
      .y_in   (dy_ff),
      .done   (cordic_done),
      .z_out  (cordic_z)
   );

   // bearing in Q3.13: round the Q16 angle by adding 4, then drop three bits
   assign z_round = cordic_z + Z_W'(4);
   assign bear    = zero_ff ? '0 : z_round[Z_W-1:3];
   assign err_raw = ERR_W'(bear) - ERR_W'(hd_ff);

   // one fold suffices: the raw error stays within three pi of zero
   always_comb begin
      err_wrap = err_raw;
      priority if (err_raw > PI_Q13) begin
         err_wrap = err_raw - TWO_PI_Q13;
      end else if (err_raw < -PI_Q13) begin
         err_wrap = err_raw + TWO_PI_Q13;
      end
   end

   assign err_mag = err_ff[ERR_W-1] ? -err_ff : err_ff;
   assign lin_sel = (err_mag < ERR_W'(dead_band_ff)) ? lin_speed_ff : '0;

   // angular: rescale with rounding, then clamp to the configured limit
   assign prod_round = prod_ang_ff + PROD_W'(2048);
   assign ang_r      = prod_round[PROD_W-1:12];
   assign ang_lim    = ANGR_W'(ang_limit_ff);

   always_comb begin
      priority if (ang_r > ang_lim) begin
         ang_clamped = ANG_W'(ang_lim);
      end else if (ang_r < -ang_lim) begin
         ang_clamped = ANG_W'(-ang_lim);
      end else begin
         ang_clamped = ANG_W'(ang_r);
      end
   end

   // near the goal, scale speed by twice the distance
   assign lin_final = near_ff ? prod_lin_ff[LPROD_W-1:LIN_W] : lin_sel_ff;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      seq_in       = seq_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      // drop the output word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            state_in = stop_ff ? ST_FIN : ST_ROT;
         end
         ST_ROT: begin
            if (cordic_done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (load_out) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               seq_in       = seq_ff + 1'b1;
               rsp_cnt_in   = seq_ff + 1'b1;
               rsp_lin_in   = stop_ff ? '0 : lin_final;
               rsp_ang_in   = stop_ff ? '0 : ang_clamped;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
         rsp_lin_ff   <= '0;
         rsp_ang_ff   <= '0;
         rsp_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
         rsp_lin_ff   <= rsp_lin_in;
         rsp_ang_ff   <= rsp_ang_in;
         rsp_cnt_ff   <= rsp_cnt_in;
      end
   end

   // configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_gain_ff  <= ANG_GAIN_RST;
         lin_speed_ff <= LIN_SPEED_RST;
         dead_band_ff <= DEAD_BAND_RST;
         ang_limit_ff <= ANG_LIMIT_RST;
         stop_dist_ff <= STOP_DIST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ANG_GAIN:  ang_gain_ff  <= csr_wdata;
            CSR_LIN_SPEED: lin_speed_ff <= csr_wdata[CFG_W-1:0];
            CSR_DEAD_BAND: dead_band_ff <= csr_wdata[CFG_W-1:0];
            CSR_ANG_LIMIT: ang_limit_ff <= csr_wdata[CFG_W-1:0];
            CSR_STOP_DIST: stop_dist_ff <= csr_wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         // exact 33-bit differences
         dx_ff   <= {req_target_x[POS_W-1], req_target_x} - {req_pos_x[POS_W-1], req_pos_x};
         dy_ff   <= {req_target_y[POS_W-1], req_target_y} - {req_pos_y[POS_W-1], req_pos_y};
         hd_ff   <= req_robot_heading;
         dist_ff <= req_target_dist;
         stop_ff <= req_goal_reached || req_hit_obstacle ||
                    (req_target_dist < DIST_W'(stop_dist_ff));
      end
      if (state_ff == ST_PRE) begin
         zero_ff <= (dx_ff == '0) && (dy_ff == '0);
      end
      if (state_ff == ST_ERR) begin
         err_ff <= err_wrap;
      end
      if (state_ff == ST_MUL) begin
         prod_ang_ff <= $signed({1'b0, ang_gain_ff}) * err_ff;
         prod_lin_ff <= lin_sel * dist_ff[LIN_W-1:0];
         lin_sel_ff  <= lin_sel;
         near_ff     <= (dist_ff < HALF_METRE_Q16);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_cmd  = rsp_lin_ff;
   assign rsp_angular_cmd = rsp_ang_ff;
   assign rsp_cmd_count   = rsp_cnt_ff;

   // checks
   `HPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall, "accepted word did not stall the request channel")
   `HPC_ASSERT_NOW(a_cordic_done_in_rot, clock, reset, cordic_done, state_ff == ST_ROT, "CORDIC finished outside its sequencer step")
   `HPC_ASSERT_NEXT(a_stop_zero, clock, reset, load_out && stop_ff, (rsp_linear_cmd == '0) && (rsp_angular_cmd == '0), "stop word produced nonzero command")

endmodule
